[hdl/ddo_pkg.sv]
`default_nettype none
package ddo_pkg;

	// Input item kinds
	localparam logic [1:0] KIND_SPEED = 2'd0;
	localparam logic [1:0] KIND_SET_X = 2'd1;
	localparam logic [1:0] KIND_SET_Y = 2'd2;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_INV_WHEEL_BASE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INV_STEER       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STRAIGHT_THRESH = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_ENABLE   = 2'd3;

	localparam logic [15:0] RST_INV_WHEEL_BASE  = 16'd512;
	localparam logic [15:0] RST_INV_STEER       = 16'd3641;
	localparam logic [15:0] RST_STRAIGHT_THRESH = 16'd51;

	localparam int IN_W  = 112;
	localparam int OUT_W = 128;

	// Radians to binary angle, Q16
	localparam logic signed [30:0] ANG_K = 31'sd683565276;

	// Polynomial sine constants, Q14
	localparam logic [15:0] Q14_PI     = 16'd51472;
	localparam logic [14:0] Q14_2PI_M5 = 15'd21024;
	localparam logic [11:0] Q14_PI_M3  = 12'd2320;
	localparam logic [14:0] Q14_ONE    = 15'd16384;
	localparam logic [15:0] QUARTER    = 16'd16384;

	// Sine unit: angles issued per sample and pipeline depth
	localparam int NUM_ANG  = 8;
	localparam int TRIG_LAT = 4;
	localparam int TRIG_CYC = NUM_ANG + TRIG_LAT;

	// Arc divider widths
	localparam int DIVN_W = 42;
	localparam int DIVD_W = 33;

	typedef struct packed {
		logic       accept;
		logic       m1;
		logic       m2;
		logic       m3;
		logic       trig_issue;
		logic [2:0] ang_sel;
		logic       m5;
		logic       m6;
		logic       div_start;
		logic       div_take;
		logic       upd;
	} cmd_t;

	typedef struct packed {
		logic straight;
		logic oe;
		logic out_busy;
		logic div_busy;
	} sts_t;

	function automatic logic [15:0] sat16(input logic signed [25:0] v);
		logic [15:0] r;
		if (v > 26'sd32767) begin
			r = 16'h7FFF;
		end else if (v < -26'sd32768) begin
			r = 16'h8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

[hdl/differential_drive_odometry_core.sv]
`default_nettype none
// Differential-drive odometry. Each speed sample (tuser kind 0) advances the
// pose by dt = stamp - previous stamp seconds, forward speed (right+left)/2 and
// turn rate (right-left)*inv_wheel_base; small turn rates take a midpoint
// Runge-Kutta step, larger ones an exact arc step. Kinds 1 and 2 overwrite x or
// y at once and produce nothing; kind 3 is dropped. A result is sent per speed
// sample only while output_enable is set. Timing: one sample at a time; a
// straight step holds the input side through three multiply steps, the
// eight angles pushed through the 4-stage sine pipeline, two product steps
// and the update step, in which its result is registered. An arc step adds
// the wait for the two 42-bit dividers, which retire one quotient bit per
// cycle, plus the take step. Set items leave the sequencer idle. The result
// register frees the input side: the next sample is taken while a result
// still waits for its transfer; that sample then holds in its update step
// until the transfer happens. Configuration is to be written by the user only
// while the block is idle; the block itself does not enforce this.
module differential_drive_odometry_core (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// right_speed, left_speed, steer_reading, stamp_seconds, set_value
	input  wire logic [ddo_pkg::IN_W-1:0]       s_tdata,
	// kind
	input  wire logic [1:0]                     s_tuser,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	// x_position, y_position, heading, velocity_x, velocity_y, turn_rate
	output logic [ddo_pkg::OUT_W-1:0]           m_tdata,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	input  wire logic                           cfg_we,
	input  wire logic [ddo_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [15:0]                    cfg_data
);
	import ddo_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// Sequencer: walks one sample through the datapath steps
	ddo_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.kind    (s_tuser),
		.sts     (sts),
		.s_tready(s_tready),
		.cmd     (cmd)
	);

	// Datapath: registers, pose state, sine unit, dividers, result register
	ddo_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata)
	);

endmodule
`default_nettype wire

[hdl/ddo_sin.sv]
`default_nettype none
module ddo_sin (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic [15:0]        angle,
	input  wire logic [2:0]         in_tag,
	output logic                    out_valid,
	output logic signed [15:0]      value,
	output logic [2:0]              out_tag
);
	import ddo_pkg::*;

	logic [14:0] x;
	logic [29:0] m1;
	logic [26:0] m2;
	logic [29:0] m3;
	logic [30:0] m4;

	logic [14:0] x_s1, x2_s1, x_s2, x2_s2, t_s2, x_s3;
	logic [15:0] t_s3, r_s4;
	logic        neg_s1, neg_s2, neg_s3, neg_s4;
	logic [2:0]  tag_s1, tag_s2, tag_s3, tag_s4;
	logic [3:0]  vld_q;

	// Fold into the first quadrant
	assign x  = angle[14] ? (Q14_ONE - {1'b0, angle[13:0]}) : {1'b0, angle[13:0]};
	assign m1 = x * x;
	assign m2 = Q14_PI_M3 * x2_s1;
	assign m3 = x2_s2 * t_s2;
	assign m4 = x_s3 * t_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		x_s1   <= x;
		x2_s1  <= m1[28:14];
		neg_s1 <= angle[15];
		tag_s1 <= in_tag;
		x_s2   <= x_s1;
		x2_s2  <= x2_s1;
		t_s2   <= Q14_2PI_M5 - {2'b0, m2[26:14]};
		neg_s2 <= neg_s1;
		tag_s2 <= tag_s1;
		x_s3   <= x_s2;
		t_s3   <= Q14_PI - m3[29:14];
		neg_s3 <= neg_s2;
		tag_s3 <= tag_s2;
		r_s4   <= m4[30:15];
		neg_s4 <= neg_s3;
		tag_s4 <= tag_s3;
	end

	assign out_valid = vld_q[3];
	assign value     = neg_s4 ? -$signed(r_s4) : $signed(r_s4);
	assign out_tag   = tag_s4;

endmodule
`default_nettype wire

[hdl/ddo_div.sv]
`default_nettype none
module ddo_div (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire logic [ddo_pkg::DIVN_W-1:0]     dividend,
	input  wire logic [ddo_pkg::DIVD_W-1:0]     divisor,
	output logic                                busy,
	output logic [ddo_pkg::DIVN_W-1:0]          quotient
);
	import ddo_pkg::*;

	localparam int CNT_W = $clog2(DIVN_W + 1);

	logic [DIVD_W-1:0] rem_q, dvs_q;
	logic [DIVN_W-1:0] quo_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic [DIVD_W:0]   trial, diff;

	// One quotient bit per cycle, restoring
	assign trial = {rem_q, quo_q[DIVN_W-1]};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(DIVN_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!diff[DIVD_W]) begin
				rem_q <= diff[DIVD_W-1:0];
				quo_q <= {quo_q[DIVN_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[DIVD_W-1:0];
				quo_q <= {quo_q[DIVN_W-2:0], 1'b0};
			end
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

[hdl/ddo_datapath.sv]
`default_nettype none
module ddo_datapath (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire ddo_pkg::cmd_t                      cmd,
	output ddo_pkg::sts_t                           sts,
	input  wire logic                               cfg_we,
	input  wire logic [ddo_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [15:0]                        cfg_data,
	input  wire logic [ddo_pkg::IN_W-1:0]           s_tdata,
	input  wire logic [1:0]                         s_tuser,
	input  wire logic                               m_tready,
	output logic                                    m_tvalid,
	output logic [ddo_pkg::OUT_W-1:0]               m_tdata
);
	import ddo_pkg::*;

	logic [15:0] iwb_q, isf_q, thr_q;
	logic        oe_q;
	logic [31:0] pose_x_q, pose_y_q, last_q;
	logic [15:0] head_q;

	logic signed [15:0] r_q, l_q, st_q;
	logic signed [31:0] dt_q;
	logic signed [16:0] v2_q;
	logic signed [32:0] om_q;
	logic signed [31:0] p_q;
	logic [32:0]        w_q;
	logic [15:0]        alpha_q, h1_q, mid_q;
	logic signed [38:0] vd_q, px_q, py_q;
	logic               straight_q;
	logic signed [15:0] sc_q [NUM_ANG];
	logic signed [32:0] vxp_q, vyp_q;
	logic signed [33:0] nx_q, ny_q;
	logic               sx_q, sy_q;
	logic [31:0]        dx_q, dy_q;

	logic               out_vld_q;
	logic [31:0]        ox_q, oy_q;
	logic [15:0]        oh_q, ovx_q, ovy_q, otr_q;

	// Step 1
	logic signed [16:0] diff_rl, v2_n;
	logic signed [33:0] om_full;
	logic signed [32:0] p_full;
	// Step 2
	logic signed [63:0] omk, omk_r, pk, pk_r;
	logic signed [48:0] vd_full;
	// Step 3
	logic [32:0] dt33, prod, pr_a, pr_b, om_abs;
	// Sine unit
	logic [15:0]        ang_base, ang;
	logic               tv;
	logic signed [15:0] tval;
	logic [2:0]         ttag;
	// Step 5
	logic signed [54:0] pxf, pyf;
	logic signed [16:0] ds, dc;
	// Step 6 and divide
	logic signed [38:0] rx, ry;
	logic signed [42:0] nxs, nys;
	logic [42:0]        nx_mag, ny_mag;
	logic               bx, by;
	logic [DIVN_W-1:0]  qx, qy;
	// Output
	logic signed [32:0] vxr, vyr, omr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iwb_q <= RST_INV_WHEEL_BASE;
			isf_q <= RST_INV_STEER;
			thr_q <= RST_STRAIGHT_THRESH;
			oe_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_INV_WHEEL_BASE:  iwb_q <= cfg_data;
				REG_INV_STEER:       isf_q <= cfg_data;
				REG_STRAIGHT_THRESH: thr_q <= cfg_data;
				REG_OUTPUT_ENABLE:   oe_q  <= cfg_data[0];
				default:             oe_q  <= oe_q;
			endcase
		end
	end

	// Pose state: set items write on the transfer, samples on update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pose_x_q <= '0;
			pose_y_q <= '0;
			head_q   <= '0;
			last_q   <= '0;
		end else if (cmd.accept) begin
			case (s_tuser)
				KIND_SPEED: last_q   <= s_tdata[79:48];
				KIND_SET_X: pose_x_q <= s_tdata[111:80];
				KIND_SET_Y: pose_y_q <= s_tdata[111:80];
				default:    last_q   <= last_q;
			endcase
		end else if (cmd.upd) begin
			pose_x_q <= pose_x_q + dx_q;
			pose_y_q <= pose_y_q + dy_q;
			head_q   <= h1_q;
		end
	end

	assign diff_rl = {r_q[15], r_q} - {l_q[15], l_q};
	assign v2_n    = {r_q[15], r_q} + {l_q[15], l_q};
	assign om_full = diff_rl * $signed({1'b0, iwb_q});
	assign p_full  = st_q * $signed({1'b0, isf_q});

	assign omk     = om_q * ANG_K;
	assign omk_r   = omk + 64'sd32768;
	assign pk      = p_q * ANG_K;
	assign pk_r    = pk + 64'sd549755813888;
	assign vd_full = v2_q * dt_q;

	assign dt33   = {dt_q[31], dt_q};
	assign prod   = w_q * dt33;
	assign pr_a   = prod + 33'h8000;
	assign pr_b   = prod + 33'h10000;
	assign om_abs = om_q[32] ? 33'(-om_q) : 33'(om_q);

	always_comb begin
		case (cmd.ang_sel[2:1])
			2'd0:    ang_base = alpha_q;
			2'd1:    ang_base = mid_q;
			2'd2:    ang_base = head_q;
			default: ang_base = h1_q;
		endcase
		ang = cmd.ang_sel[0] ? ang_base + QUARTER : ang_base;
	end

	ddo_sin u_sin (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cmd.trig_issue),
		.angle    (ang),
		.in_tag   (cmd.ang_sel),
		.out_valid(tv),
		.value    (tval),
		.out_tag  (ttag)
	);

	// Result slots: sin/cos of steer angle, mid, old heading, new heading
	assign pxf = vd_q * sc_q[3];
	assign pyf = vd_q * sc_q[2];
	assign ds  = {sc_q[6][15], sc_q[6]} - {sc_q[4][15], sc_q[4]};
	assign dc  = {sc_q[7][15], sc_q[7]} - {sc_q[5][15], sc_q[5]};

	assign rx     = px_q + 39'sd64;
	assign ry     = py_q + 39'sd64;
	assign nxs    = {nx_q, 9'b0};
	assign nys    = {ny_q, 9'b0};
	assign nx_mag = nxs[42] ? 43'(-nxs) : 43'(nxs);
	assign ny_mag = nys[42] ? 43'(-nys) : 43'(nys);

	ddo_div u_div_x (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.dividend(nx_mag[DIVN_W-1:0]),
		.divisor (om_abs),
		.busy    (bx),
		.quotient(qx)
	);

	ddo_div u_div_y (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.dividend(ny_mag[DIVN_W-1:0]),
		.divisor (om_abs),
		.busy    (by),
		.quotient(qy)
	);

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			r_q  <= s_tdata[15:0];
			l_q  <= s_tdata[31:16];
			st_q <= s_tdata[47:32];
			dt_q <= s_tdata[79:48] - last_q;
		end
		if (cmd.m1) begin
			v2_q <= v2_n;
			om_q <= om_full[32:0];
			p_q  <= p_full[31:0];
		end
		if (cmd.m2) begin
			w_q     <= omk_r[48:16];
			alpha_q <= pk_r[55:40];
			vd_q    <= vd_full[38:0];
		end
		if (cmd.m3) begin
			h1_q       <= head_q + pr_a[31:16];
			mid_q      <= head_q + pr_b[32:17];
			straight_q <= om_abs <= {9'b0, thr_q, 8'b0};
		end
		if (tv) begin
			sc_q[ttag] <= tval;
		end
		if (cmd.m5) begin
			px_q  <= pxf[38:0];
			py_q  <= pyf[38:0];
			vxp_q <= v2_q * sc_q[1];
			vyp_q <= v2_q * sc_q[0];
			nx_q  <= v2_q * ds;
			ny_q  <= v2_q * dc;
		end
		if (cmd.m6) begin
			dx_q <= rx[38:7];
			dy_q <= ry[38:7];
			sx_q <= nx_q[33] ^ om_q[32];
			sy_q <= ny_q[33] ^ om_q[32];
		end
		if (cmd.div_take) begin
			dx_q <= sx_q ? -qx[31:0] : qx[31:0];
			dy_q <= sy_q ? qy[31:0] : -qy[31:0];
		end
	end

	assign vxr = vxp_q + 33'sd16384;
	assign vyr = vyp_q + 33'sd16384;
	assign omr = om_q + 33'sd128;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.upd && oe_q) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.upd && oe_q) begin
			ox_q  <= pose_x_q + dx_q;
			oy_q  <= pose_y_q + dy_q;
			oh_q  <= h1_q;
			ovx_q <= sat16(26'($signed(vxr[32:15])));
			ovy_q <= sat16(26'($signed(vyr[32:15])));
			otr_q <= sat16(26'($signed(omr[32:8])));
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {otr_q, ovy_q, ovx_q, oh_q, oy_q, ox_q};

	assign sts.straight = straight_q;
	assign sts.oe       = oe_q;
	assign sts.out_busy = out_vld_q && !m_tready;
	assign sts.div_busy = bx || by;

endmodule
`default_nettype wire

[hdl/ddo_ctrl.sv]
`default_nettype none
module ddo_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           s_tvalid,
	input  wire logic [1:0]     kind,
	input  wire ddo_pkg::sts_t  sts,
	output logic                s_tready,
	output ddo_pkg::cmd_t       cmd
);
	import ddo_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_M1   = 4'd1;
	localparam logic [3:0] ST_M2   = 4'd2;
	localparam logic [3:0] ST_M3   = 4'd3;
	localparam logic [3:0] ST_TRIG = 4'd4;
	localparam logic [3:0] ST_M5   = 4'd5;
	localparam logic [3:0] ST_M6   = 4'd6;
	localparam logic [3:0] ST_DIVW = 4'd7;
	localparam logic [3:0] ST_DIVT = 4'd8;
	localparam logic [3:0] ST_UPD  = 4'd9;

	logic [3:0] state_q, state_n;
	logic [3:0] cnt_q;
	logic       accept;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		state_n        = state_q;
		cmd            = '0;
		cmd.accept     = accept;
		cmd.ang_sel    = cnt_q[2:0];
		case (state_q)
			ST_IDLE: begin
				if (accept && kind == KIND_SPEED) begin
					state_n = ST_M1;
				end
			end
			ST_M1: begin
				cmd.m1  = 1'b1;
				state_n = ST_M2;
			end
			ST_M2: begin
				cmd.m2  = 1'b1;
				state_n = ST_M3;
			end
			ST_M3: begin
				cmd.m3  = 1'b1;
				state_n = ST_TRIG;
			end
			ST_TRIG: begin
				cmd.trig_issue = (cnt_q < 4'(NUM_ANG));
				if (cnt_q == 4'(TRIG_CYC - 1)) begin
					state_n = ST_M5;
				end
			end
			ST_M5: begin
				cmd.m5  = 1'b1;
				state_n = ST_M6;
			end
			ST_M6: begin
				cmd.m6        = 1'b1;
				cmd.div_start = !sts.straight;
				state_n       = sts.straight ? ST_UPD : ST_DIVW;
			end
			ST_DIVW: begin
				if (!sts.div_busy) begin
					state_n = ST_DIVT;
				end
			end
			ST_DIVT: begin
				cmd.div_take = 1'b1;
				state_n      = ST_UPD;
			end
			ST_UPD: begin
				// hold while the previous result still waits for its transfer
				if (!(sts.oe && sts.out_busy)) begin
					cmd.upd = 1'b1;
					state_n = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_n;
			if (state_q == ST_TRIG) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
		end
	end

	a_speed_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept && kind == KIND_SPEED |=> state_q == ST_M1)
		else $error("speed sample did not start the step sequence");

	a_trig_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_TRIG && cnt_q == 4'(TRIG_CYC - 1) |=> state_q == ST_M5)
		else $error("sine collection did not finish on time");

	a_arc_only: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIVW |-> !sts.straight)
		else $error("divider used on a straight step");

	a_upd_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.upd && sts.oe |-> !sts.out_busy)
		else $error("result overwritten before transfer");

endmodule
`default_nettype wire

[tb/tb_differential_drive_odometry_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// Odometry core bench. Drive speed samples, set-x/set-y items and unused kinds
// through the input stream, and predict each pose result in the bench itself.
// Check every result transfer field by field against the oldest pending pose.
// Sweep the configuration registers between phases, at their extremes too.
// Randomize both handshakes and hold the result side off once to fill the core.
module tb_differential_drive_odometry_core;
	import ddo_pkg::*;

	localparam int STALL_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 100;
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	// first member lands in the top bits of the result word
	typedef struct packed {
		logic [15:0] turn_rate;
		logic [15:0] velocity_y;
		logic [15:0] velocity_x;
		logic [15:0] heading;
		logic [31:0] y_position;
		logic [31:0] x_position;
	} pose_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic [IN_W-1:0]      s_tdata = '0;
	logic [1:0]           s_tuser = KIND_SPEED;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [OUT_W-1:0]     m_tdata;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_INV_WHEEL_BASE;
	logic [15:0]          cfg_data = '0;

	// predictor copy of the registers and the pose
	logic [15:0] wheel_base_inv = RST_INV_WHEEL_BASE;
	logic [15:0] steer_inv = RST_INV_STEER;
	logic [15:0] straight_thr = RST_STRAIGHT_THRESH;
	logic        emit_enable = 1'b0;
	logic [31:0] pose_x = '0;
	logic [31:0] pose_y = '0;
	logic [15:0] pose_hd = '0;
	logic [31:0] last_stamp = '0;

	pose_t pending_poses[$];
	int    errors = 0;
	int    idle_cycles = 0;
	bit    calm = 1'b0;      // suppress random idling on both sides
	bit    hold_rx = 1'b0;   // long receiver hold-off
	logic [31:0] next_stamp = '0;

	differential_drive_odometry_core dut (
		.clk(clk), .arst_n(arst_n),
		.s_tdata(s_tdata), .s_tuser(s_tuser), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	// Q2.14 polynomial sine of a binary angle
	function automatic longint sine_q14(input logic [15:0] ang);
		longint unsigned f, x2, t;
		f = ang[13:0];
		if (ang[14]) f = 16384 - f;
		x2 = (f * f) >> 14;
		t = (longint'(Q14_PI_M3) * x2) >> 14;
		t = longint'(Q14_2PI_M5) - t;
		t = (x2 * t) >> 14;
		t = longint'(Q14_PI) - t;
		t = (f * t) >> 15;
		return ang[15] ? -longint'(t) : longint'(t);
	endfunction

	function automatic longint cosine_q14(input logic [15:0] ang);
		return sine_q14(ang + QUARTER);
	endfunction

	// round half up after an arithmetic right shift
	function automatic longint round_down_shift(input longint v, input int s);
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic logic [15:0] clamp16(input longint v);
		if (v > 32767) return 16'h7FFF;
		if (v < -32768) return 16'h8000;
		return v[15:0];
	endfunction

	// Advance the predicted pose by one accepted item; queue a pose if emitted.
	task automatic advance_pose(input logic [1:0] kind, input logic [IN_W-1:0] d);
		longint r, l, st, dt, v2, om, w, aom, dx, dy, vd, num;
		longint unsigned prod;
		logic [31:0] dstamp;
		logic [15:0] alpha, dth, half, h1, mid;
		pose_t p;
		if (kind == KIND_SET_X) begin
			pose_x = d[111:80];
		end else if (kind == KIND_SET_Y) begin
			pose_y = d[111:80];
		end else if (kind == KIND_SPEED) begin
			r = longint'($signed(d[15:0]));
			l = longint'($signed(d[31:16]));
			st = longint'($signed(d[47:32]));
			dstamp = d[79:48] - last_stamp;
			dt = longint'($signed(dstamp));
			last_stamp = d[79:48];
			alpha = 16'(round_down_shift(st * longint'(steer_inv) * longint'(ANG_K), 40));
			v2 = r + l;
			om = (r - l) * longint'(wheel_base_inv);
			w = round_down_shift(om * longint'(ANG_K), 16);
			prod = longint'(w) * longint'(dt);
			dth = 16'((prod + 64'h8000) >> 16);
			half = 16'((prod + 64'h10000) >> 17);
			h1 = pose_hd + dth;
			aom = om < 0 ? -om : om;
			if (aom <= (longint'(straight_thr) << 8)) begin
				// midpoint step
				vd = v2 * dt;
				mid = pose_hd + half;
				dx = round_down_shift(vd * cosine_q14(mid), 7);
				dy = round_down_shift(vd * sine_q14(mid), 7);
			end else begin
				// exact arc between old and new heading
				num = v2 * 512;
				dx = (num * (sine_q14(h1) - sine_q14(pose_hd))) / om;
				dy = -((num * (cosine_q14(h1) - cosine_q14(pose_hd))) / om);
			end
			pose_x = pose_x + dx[31:0];
			pose_y = pose_y + dy[31:0];
			pose_hd = h1;
			if (emit_enable) begin
				p.x_position = pose_x;
				p.y_position = pose_y;
				p.heading = pose_hd;
				p.velocity_x = clamp16(round_down_shift(v2 * cosine_q14(alpha), 15));
				p.velocity_y = clamp16(round_down_shift(v2 * sine_q14(alpha), 15));
				p.turn_rate = clamp16(round_down_shift(om, 8));
				pending_poses.push_back(p);
			end
		end
	endtask

	task automatic report_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] want);
		if (errors < 40)
			$display("mismatch %s: got %h expected %h at %0t", field, got, want, $time);
		errors++;
	endtask

	// Offer one item until the core takes it, then maybe idle for a random gap.
	task automatic send_item(input logic [1:0] kind, input logic [15:0] r, input logic [15:0] l,
			input logic [15:0] st, input logic [31:0] stamp, input logic [31:0] setv);
		logic [IN_W-1:0] d;
		int gap;
		d = {setv, stamp, st, l, r};
		s_tdata <= d;
		s_tuser <= kind;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		advance_pose(kind, d);
		if (!calm && $urandom_range(0, 99) < 31) begin
			s_tvalid <= 1'b0;
			gap = $urandom_range(1, 6);
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_speed(input logic [15:0] r, input logic [15:0] l, input logic [15:0] st,
			input logic [31:0] stamp);
		send_item(KIND_SPEED, r, l, st, stamp, $urandom);
		next_stamp = stamp;
	endtask

	// Pause the sender until every pending pose has arrived and the core is idle.
	task automatic drain;
		s_tvalid <= 1'b0;
		while (pending_poses.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write one register; the caller lowers the write enable after its last write.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_INV_WHEEL_BASE: begin
				wheel_base_inv = val;
			end
			REG_INV_STEER: begin
				steer_inv = val;
			end
			REG_STRAIGHT_THRESH: begin
				straight_thr = val;
			end
			default: begin
				emit_enable = val[0];
			end
		endcase
	endtask

	task automatic configure(input logic [15:0] wb, input logic [15:0] sf, input logic [15:0] thr,
			input logic oe);
		drain();
		write_reg(REG_INV_WHEEL_BASE, wb);
		write_reg(REG_INV_STEER, sf);
		write_reg(REG_STRAIGHT_THRESH, thr);
		write_reg(REG_OUTPUT_ENABLE, {15'd0, oe});
		cfg_we <= 1'b0;
	endtask

	// Some set and unused items; samples mostly plausible with short dt, else full-range noise.
	task automatic send_random_item;
		int pick;
		logic [15:0] r, l;
		logic [31:0] stamp;
		pick = $urandom_range(0, 99);
		if (pick < 6) begin
			send_item(KIND_SET_X, 16'($urandom), 16'($urandom), 16'($urandom), $urandom,
				$urandom);
		end else if (pick < 12) begin
			send_item(KIND_SET_Y, 16'($urandom), 16'($urandom), 16'($urandom), $urandom,
				$urandom);
		end else if (pick < 15) begin
			send_item(KIND_UNUSED, 16'($urandom), 16'($urandom), 16'($urandom), $urandom,
				$urandom);
		end else begin
			if ($urandom_range(0, 99) < 70) begin
				r = 16'($signed($urandom_range(0, 1200)) - 600);
				l = $urandom_range(0, 3) == 0 ? r : 16'($signed($urandom_range(0, 1200)) - 600);
			end else begin
				r = 16'($urandom);
				l = 16'($urandom);
			end
			stamp = $urandom_range(0, 99) < 80 ? next_stamp + $urandom_range(0, 4) : $urandom;
			send_speed(r, l, 16'($urandom), stamp);
		end
	endtask

	// Field extremes, every kind, the unused kind, backward time and zero turn.
	task automatic test_directed;
		configure(RST_INV_WHEEL_BASE, RST_INV_STEER, RST_STRAIGHT_THRESH, 1'b1);
		send_speed(16'd256, 16'd256, 16'd0, 32'd1);            // first sample, straight
		send_speed(16'd512, 16'd256, 16'd100, 32'd3);          // turning, arc
		send_speed(16'h7FFF, 16'h7FFF, 16'h7FFF, 32'd4);       // top speeds
		send_speed(16'h8000, 16'h8000, 16'h8000, 32'd5);       // bottom speeds
		send_speed(16'h7FFF, 16'h8000, 16'h0000, 32'd6);       // widest spread
		send_speed(16'h8000, 16'h7FFF, 16'hFFFF, 32'd7);
		send_speed(16'd300, 16'd300, 16'd0, 32'd2);            // time goes backwards
		send_speed(16'd100, 16'd90, 16'd50, 32'hFFFF_FFFF);    // top stamp, small negative dt
		send_speed(16'd100, 16'd90, 16'd50, 32'd0);            // wrap forward
		send_speed(16'd0, 16'd0, 16'd0, 32'd0);                // no motion
		send_item(KIND_SET_X, 16'd1, 16'd2, 16'd3, 32'd99, 32'h7FFF_FFFF);
		send_item(KIND_SET_Y, 16'd1, 16'd2, 16'd3, 32'd99, 32'h8000_0000);
		send_item(KIND_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_speed(16'd256, 16'd0, 16'd0, 32'd1);              // position wraps
		send_item(KIND_SET_X, 16'd0, 16'd0, 16'd0, 32'd0, 32'h0);
		send_item(KIND_SET_Y, 16'd0, 16'd0, 16'd0, 32'd0, 32'hFFFF_FFFF);
		send_speed(16'd10, 16'd10, 16'd0, 32'd3);
		// output disabled: pose still moves
		configure(RST_INV_WHEEL_BASE, RST_INV_STEER, RST_STRAIGHT_THRESH, 1'b0);
		send_speed(16'd400, 16'd200, 16'd20, 32'd5);
		send_speed(16'd100, 16'd100, 16'd20, 32'd6);
		// turn rate exactly on the threshold stays on the midpoint branch
		configure({RST_STRAIGHT_THRESH[7:0], 8'd0}, RST_INV_STEER, RST_STRAIGHT_THRESH, 1'b1);
		send_speed(16'd301, 16'd300, 16'd10, 32'd8);
		send_speed(16'd300, 16'd301, 16'd10, 32'd9);
		send_speed(16'd302, 16'd300, 16'd10, 32'd10);
	endtask

	// Run a batch of random items under several register settings.
	task automatic test_config_sweep;
		logic [15:0] wb[6] = '{16'd0, 16'hFFFF, 16'd512, 16'd64, 16'd2000, 16'd1};
		logic [15:0] sf[6] = '{16'hFFFF, 16'd0, 16'd3641, 16'd20000, 16'd1, 16'd800};
		logic [15:0] th[6] = '{16'd0, 16'hFFFF, 16'd51, 16'd0, 16'd200, 16'hFFFF};
		for (int k = 0; k < 6; k++) begin
			configure(wb[k], sf[k], th[k], k != 4);
			repeat (40) send_random_item();
		end
	endtask

	task automatic test_random;
		configure(16'($urandom_range(0, 4000)), 16'($urandom), 16'($urandom_range(0, 400)),
			1'b1);
		repeat (200) send_random_item();
		calm = 1'b1;              // a stretch with no idling on either side
		repeat (100) send_random_item();
		calm = 1'b0;
		configure(16'($urandom), 16'($urandom), 16'($urandom), 1'b1);
		repeat (200) send_random_item();
	endtask

	// Hold the result side off while samples keep coming, so the input stalls.
	task automatic test_backpressure;
		configure(RST_INV_WHEEL_BASE, RST_INV_STEER, RST_STRAIGHT_THRESH, 1'b1);
		fork
			begin
				hold_rx = 1'b1;
				repeat (1500) @(posedge clk);
				hold_rx = 1'b0;
			end
		join_none
		repeat (40) send_random_item();
		drain();
	endtask

	// result side: random ready, long hold-off on request
	always @(posedge clk) begin
		if (hold_rx)
			m_tready <= 1'b0;
		else
			m_tready <= calm || $urandom_range(0, 99) >= 31;
	end

	// compare every result transfer with the oldest pending pose
	always @(posedge clk) begin
		pose_t got, want;
		if (m_tvalid && m_tready) begin
			got = m_tdata;
			if (pending_poses.size() == 0) begin
				report_mismatch("unexpected result", got.x_position, 32'h0);
			end else begin
				want = pending_poses.pop_front();
				if (got.x_position !== want.x_position)
					report_mismatch("x_position", got.x_position, want.x_position);
				if (got.y_position !== want.y_position)
					report_mismatch("y_position", got.y_position, want.y_position);
				if (got.heading !== want.heading)
					report_mismatch("heading", got.heading, want.heading);
				if (got.velocity_x !== want.velocity_x)
					report_mismatch("velocity_x", got.velocity_x, want.velocity_x);
				if (got.velocity_y !== want.velocity_y)
					report_mismatch("velocity_y", got.velocity_y, want.velocity_y);
				if (got.turn_rate !== want.turn_rate)
					report_mismatch("turn_rate", got.turn_rate, want.turn_rate);
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_config_sweep();
		test_random();
		test_backpressure();
		drain();
		if (errors == 0 && pending_poses.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
`default_nettype wire
